// ----- rtl/msd_pkg.sv -----
// Shared types and constants for the mouse shake detector.
package msd_pkg;

  localparam int unsigned MoveWidth = 16;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned PosWidth = 32;
  localparam int unsigned DistWidth = 32;
  localparam int unsigned ThreshWidth = 16;
  localparam int unsigned LimitWidth = 4;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic DefaultEnable = 1'b1;
  localparam logic [ThreshWidth-1:0] DefaultThreshold = 16'd400;
  localparam logic [LimitWidth-1:0] DefaultTurnLimit = 4'd3;
  localparam logic [TimeWidth-1:0] DefaultWindowUs = 32'd400000;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DETECT_ENABLE = 2'd0,
    CFG_DISTANCE_THRESHOLD = 2'd1,
    CFG_TURN_LIMIT = 2'd2,
    CFG_TIME_WINDOW_US = 2'd3
  } msd_cfg_index_t;

  typedef struct packed {
    logic detect_enable;
    logic [ThreshWidth-1:0] distance_threshold;
    logic [LimitWidth-1:0] turn_limit;
    logic [TimeWidth-1:0] time_window_us;
  } msd_cfg_t;

  typedef struct packed {
    logic signed [MoveWidth-1:0] movement;
    logic is_absolute;
    logic [TimeWidth-1:0] time_us;
  } msd_item_t;

endpackage

// ----- rtl/msd_move_if.sv -----
// Channel interface carrying pointer movement transactions.
interface msd_move_if
  import msd_pkg::*;
;
  logic valid;
  logic ready;
  logic signed [MoveWidth-1:0] movement;
  logic is_absolute;
  logic [TimeWidth-1:0] time_us;

  modport source (output valid, output movement, output is_absolute, output time_us,
                  input ready);
  modport sink (input valid, input movement, input is_absolute, input time_us,
                output ready);
endinterface

// ----- rtl/msd_result_if.sv -----
// Channel interface carrying shake result transactions.
interface msd_result_if;
  logic valid;
  logic ready;
  logic shaking;

  modport source (output valid, output shaking, input ready);
  modport sink (input valid, input shaking, output ready);
endinterface

// ----- rtl/msd_tracker.sv -----
// Movement tracking state and the per-item shake decision.
module msd_tracker
  import msd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  msd_item_t item,
  input  msd_cfg_t  cfg,
  output logic      shake
);

  logic [PosWidth-1:0] position, position_next;
  logic [DistWidth-1:0] distance_sum, distance_sum_next;
  logic direction_negative, direction_negative_next;
  logic [CountWidth-1:0] turn_count, turn_count_next;
  logic [TimeWidth-1:0] last_turn_time, last_turn_time_next;

  logic signed [PosWidth:0] move_ext;
  logic signed [PosWidth:0] pos_ext;
  logic signed [PosWidth:0] dx;
  logic [PosWidth:0] magnitude;
  logic [DistWidth+1:0] sum_wide;
  logic [DistWidth-1:0] sum_sat;
  logic reversal;
  logic in_window;
  logic [TimeWidth-1:0] elapsed;
  logic [CountWidth-1:0] count_inc;

  always_comb begin
    move_ext = {{(PosWidth + 1 - MoveWidth){item.movement[MoveWidth-1]}}, item.movement};
    pos_ext = {position[PosWidth-1], position};
    dx = item.is_absolute ? (move_ext - pos_ext) : move_ext;
    magnitude = dx[PosWidth] ? (~dx + 1'b1) : dx;
    sum_wide = {2'b00, distance_sum} + {1'b0, magnitude};
    sum_sat = (sum_wide[DistWidth+1:DistWidth] != 2'b00) ? '1 : sum_wide[DistWidth-1:0];
    reversal = (dx != '0) && (dx[PosWidth] != direction_negative);
    elapsed = item.time_us - last_turn_time;
    in_window = elapsed < cfg.time_window_us;
    count_inc = turn_count + 1'b1;

    position_next = position;
    distance_sum_next = distance_sum;
    direction_negative_next = direction_negative;
    turn_count_next = turn_count;
    last_turn_time_next = last_turn_time;
    shake = 1'b0;

    if (cfg.detect_enable) begin
      position_next = item.is_absolute ? move_ext[PosWidth-1:0]
                                       : position + move_ext[PosWidth-1:0];
      distance_sum_next = sum_sat;
      if (reversal) begin
        direction_negative_next = ~direction_negative;
        last_turn_time_next = item.time_us;
        if (in_window) begin
          if (sum_sat > {{(DistWidth - ThreshWidth){1'b0}}, cfg.distance_threshold}) begin
            turn_count_next = count_inc;
            distance_sum_next = '0;
            // A completed shake restarts the count but keeps the old turn time.
            if (count_inc > {{(CountWidth - LimitWidth){1'b0}}, cfg.turn_limit}) begin
              turn_count_next = '0;
              last_turn_time_next = last_turn_time;
              shake = 1'b1;
            end
          end
        end else begin
          turn_count_next = '0;
          distance_sum_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      distance_sum <= '0;
      direction_negative <= 1'b0;
      turn_count <= '0;
      last_turn_time <= '0;
    end else if (fire) begin
      position <= position_next;
      distance_sum <= distance_sum_next;
      direction_negative <= direction_negative_next;
      turn_count <= turn_count_next;
      last_turn_time <= last_turn_time_next;
    end
  end

endmodule

// ----- rtl/mouse_shake_detector.sv -----
// Top level of the mouse shake detector: registers, handshake and tracker.
//
// Usage: movement transactions (signed x delta or absolute x position, plus a
// microsecond timestamp) enter on the movement channel; each one produces
// exactly one result transaction carrying the shaking flag.
// The input side registers the transaction, the tracker decides combinationally
// and the decision lands in the result register once that register is free.
// A new transaction can be accepted every cycle unless a waiting result is
// not taken by the receiver.
// The result register and the input register form a two-entry pipeline: while
// a result waits, the next transaction is still accepted into the input
// register; it moves on only when the receiver takes the waiting result.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should be changed only while no transaction is in flight.
// Reset (synchronous, active high) empties the pipeline, restores default
// configuration and clears position, distance, direction, count and time.
module mouse_shake_detector
  import msd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  msd_move_if.sink                 movement_ch,
  msd_result_if.source             result_ch
);

  msd_cfg_t cfg;
  msd_item_t item;
  logic item_valid;
  logic advance;
  logic shake;
  logic result_valid;
  logic result_shaking;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_enable <= DefaultEnable;
      cfg.distance_threshold <= DefaultThreshold;
      cfg.turn_limit <= DefaultTurnLimit;
      cfg.time_window_us <= DefaultWindowUs;
    end else if (cfg_we) begin
      unique case (msd_cfg_index_t'(cfg_index))
        CFG_DETECT_ENABLE: cfg.detect_enable <= cfg_data[0];
        CFG_DISTANCE_THRESHOLD: cfg.distance_threshold <= cfg_data[ThreshWidth-1:0];
        CFG_TURN_LIMIT: cfg.turn_limit <= cfg_data[LimitWidth-1:0];
        CFG_TIME_WINDOW_US: cfg.time_window_us <= cfg_data[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  assign advance = item_valid && (!result_valid || result_ch.ready);
  assign movement_ch.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (movement_ch.ready) begin
      item_valid <= movement_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (movement_ch.valid && movement_ch.ready) begin
      item.movement <= movement_ch.movement;
      item.is_absolute <= movement_ch.is_absolute;
      item.time_us <= movement_ch.time_us;
    end
  end

  msd_tracker u_tracker (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (item),
    .cfg   (cfg),
    .shake (shake)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_shaking <= shake;
    end
  end

  assign result_ch.valid = result_valid;
  assign result_ch.shaking = result_shaking;

endmodule

// ----- sim/mouse_shake_detector_tb.sv -----
// Self-checking testbench for the mouse shake detector, with its own shake predictor.
`timescale 1ns / 1ps

module mouse_shake_detector_tb
  import msd_pkg::*;
;

  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic signed [MoveWidth-1:0] movement;
    logic is_absolute;
    logic [TimeWidth-1:0] time_us;
    logic fixed;
    logic shaking;
  } move_row_t;

  // Opening sequence under the reset configuration. A set fixed bit means the
  // shaking value is given in the row rather than by the predictor.
  localparam move_row_t MoveRows [16] = '{
    '{16'sh7FFF, 1'b0, 32'd100, 1'b1, 1'b0},
    '{16'sh8000, 1'b0, 32'd1000, 1'b0, 1'b0},
    '{16'sh7FFF, 1'b0, 32'd2000, 1'b0, 1'b0},
    '{16'sh8000, 1'b0, 32'd3000, 1'b0, 1'b0},
    '{16'sd500, 1'b0, 32'd4000, 1'b1, 1'b1},
    '{16'sd0, 1'b0, 32'd5000, 1'b1, 1'b0},
    '{16'sh8000, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b0},
    '{16'sd1000, 1'b0, 32'h0000_0100, 1'b0, 1'b0},
    '{16'sh7FFF, 1'b1, 32'h0000_0200, 1'b0, 1'b0},
    '{16'sh8000, 1'b1, 32'h0000_0300, 1'b0, 1'b0},
    '{16'sd1, 1'b0, 32'h0000_0300, 1'b0, 1'b0},
    '{-16'sd401, 1'b0, 32'h0000_0400, 1'b0, 1'b0},
    '{16'sd401, 1'b0, 32'h0000_0500, 1'b0, 1'b0},
    '{-16'sd2000, 1'b0, 32'd401024, 1'b0, 1'b0},
    '{16'sd2000, 1'b0, 32'd801023, 1'b0, 1'b0},
    '{-16'sd32767, 1'b1, 32'd801100, 1'b1, 1'b0}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  msd_move_if move_ch ();
  msd_result_if res_ch ();

  mouse_shake_detector dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .movement_ch(move_ch),
    .result_ch(res_ch)
  );

  // Predictor copy of the configuration and tracker state.
  msd_cfg_t model_cfg;
  logic [PosWidth-1:0] model_pos;
  logic [DistWidth-1:0] model_dist;
  logic model_dir_neg;
  logic [CountWidth-1:0] model_turns;
  logic [TimeWidth-1:0] model_last_turn;

  bit pending_shake_q[$];
  int unsigned fail_count;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned rx_hold_left;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit predict_shake(input logic signed [MoveWidth-1:0] mv,
                                       input logic absf, input logic [TimeWidth-1:0] t);
    logic signed [32:0] mv_x;
    logic signed [32:0] pos_x;
    logic signed [32:0] dx;
    logic [32:0] mag;
    logic [33:0] sum;
    logic [TimeWidth-1:0] elapsed;
    bit rev;
    if (!model_cfg.detect_enable) return 1'b0;
    mv_x = 33'(mv);
    pos_x = $signed({model_pos[PosWidth-1], model_pos});
    dx = absf ? mv_x - pos_x : mv_x;
    model_pos = model_pos + dx[PosWidth-1:0];
    mag = dx[32] ? -dx : dx;
    sum = {2'b00, model_dist} + {1'b0, mag};
    model_dist = (sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[DistWidth-1:0];
    rev = (dx[32] && !model_dir_neg) || (!dx[32] && dx != 0 && model_dir_neg);
    if (!rev) return 1'b0;
    model_dir_neg = !model_dir_neg;
    elapsed = t - model_last_turn;
    if (elapsed < model_cfg.time_window_us) begin
      if (model_dist > {16'd0, model_cfg.distance_threshold}) begin
        model_turns = model_turns + 5'd1;
        model_dist = '0;
        if (model_turns > {1'b0, model_cfg.turn_limit}) begin
          // A reported shake leaves the last turn time where it was.
          model_turns = '0;
          return 1'b1;
        end
      end
    end else begin
      model_turns = '0;
      model_dist = '0;
    end
    model_last_turn = t;
    return 1'b0;
  endfunction

  task automatic write_reg(input msd_cfg_index_t idx, input logic [CfgDataWidth-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DETECT_ENABLE: model_cfg.detect_enable = val[0];
      CFG_DISTANCE_THRESHOLD: model_cfg.distance_threshold = val[ThreshWidth-1:0];
      CFG_TURN_LIMIT: model_cfg.turn_limit = val[LimitWidth-1:0];
      CFG_TIME_WINDOW_US: model_cfg.time_window_us = val[TimeWidth-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one movement transaction and records its expected result once accepted.
  task automatic send_move(input logic signed [MoveWidth-1:0] mv, input logic absf,
                           input logic [TimeWidth-1:0] t, input bit fixed,
                           input bit fixed_shake);
    bit shk;
    while ($urandom_range(0, 99) < idle_pct) begin
      move_ch.valid <= 1'b0;
      @(posedge clk);
    end
    move_ch.valid <= 1'b1;
    move_ch.movement <= mv;
    move_ch.is_absolute <= absf;
    move_ch.time_us <= t;
    @(posedge clk);
    while (move_ch.ready !== 1'b1) @(posedge clk);
    shk = predict_shake(mv, absf, t);
    pending_shake_q.push_back(fixed ? fixed_shake : shk);
  endtask

  task automatic wait_drained();
    move_ch.valid <= 1'b0;
    while (pending_shake_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : result_monitor
    bit want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_shake_q.size() == 0) begin
          $error("shaking: expected none, actual %0b", res_ch.shaking);
          fail_count++;
        end else begin
          want = pending_shake_q.pop_front();
          if (res_ch.shaking !== want) begin
            $error("shaking: expected %0b, actual %0b", want, res_ch.shaking);
            fail_count++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int p;
    int n;
    int items;
    int mag;
    int delta;
    int target;
    int lim;
    logic signed [MoveWidth-1:0] mv;
    logic absf;
    logic [TimeWidth-1:0] t;
    logic [TimeWidth-1:0] now_us;
    logic [TimeWidth-1:0] step_max;
    bit want_neg;
    msd_cfg_t phase_cfg;

    fail_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    rx_hold_left = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DETECT_ENABLE;
    cfg_data <= '0;
    move_ch.valid <= 1'b0;
    move_ch.movement <= '0;
    move_ch.is_absolute <= 1'b0;
    move_ch.time_us <= '0;

    model_cfg = '{DefaultEnable, DefaultThreshold, DefaultTurnLimit, DefaultWindowUs};
    model_pos = '0;
    model_dist = '0;
    model_dir_neg = 1'b0;
    model_turns = '0;
    model_last_turn = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (MoveRows[i]) begin
      send_move(MoveRows[i].movement, MoveRows[i].is_absolute, MoveRows[i].time_us,
                MoveRows[i].fixed, MoveRows[i].shaking);
    end
    wait_drained();

    now_us = 32'd801200;
    want_neg = 1'b0;
    for (p = 0; p < 8; p++) begin
      case (p)
        0, 7: phase_cfg = '{1'b1, 16'd400, 4'd3, 32'd400000};
        1: phase_cfg = '{1'b1, 16'd0, 4'd0, 32'hFFFF_FFFF};
        2: phase_cfg = '{1'b1, 16'hFFFF, 4'hF, 32'd0};
        3: phase_cfg = '{1'b1, 16'($urandom_range(0, 3000)), 4'($urandom_range(0, 15)),
                         32'($urandom_range(1000, 3000000))};
        4: phase_cfg = '{1'b1, 16'd1, 4'd1, 32'd1};
        5: phase_cfg = '{1'b0, 16'($urandom), 4'($urandom), 32'($urandom)};
        default: phase_cfg = '{1'b1, 16'($urandom_range(0, 20000)), 4'($urandom),
                               32'($urandom)};
      endcase
      write_reg(CFG_DISTANCE_THRESHOLD, {16'd0, phase_cfg.distance_threshold});
      write_reg(CFG_TURN_LIMIT, {28'd0, phase_cfg.turn_limit});
      write_reg(CFG_TIME_WINDOW_US, phase_cfg.time_window_us);
      write_reg(CFG_DETECT_ENABLE, {31'd0, phase_cfg.detect_enable});

      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          // The receiver holds off while the sender keeps offering transactions.
          rx_hold_left = 120;
        end
        1: begin
          idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          idle_pct = 8;
          stall_pct = 8;
        end
      endcase

      items = (p == 5) ? 40 : 260;
      for (n = 0; n < items; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          mv = 16'($urandom);
          absf = 1'($urandom_range(0, 1));
          t = $urandom;
        end else begin
          // Shake-like movement: runs in one direction that flip now and then.
          if ($urandom_range(0, 99) < 35) want_neg = !want_neg;
          lim = int'(model_cfg.distance_threshold) / 2 + 2;
          if (lim > 32767) lim = 32767;
          case ($urandom_range(0, 2))
            0: mag = $urandom_range(1, 64);
            1: mag = $urandom_range(1, lim);
            default: mag = $urandom_range(1, 32767);
          endcase
          if ($urandom_range(0, 99) < 4) mag = 0;
          delta = want_neg ? -mag : mag;
          if ($urandom_range(0, 99) < 20 && $signed(model_pos) >= -32768 &&
              $signed(model_pos) <= 32767) begin
            target = $signed(model_pos) + delta;
            if (target > 32767) target = 32767;
            if (target < -32768) target = -32768;
            absf = 1'b1;
            mv = 16'(target);
          end else begin
            absf = 1'b0;
            mv = 16'(delta);
          end
          step_max = (model_cfg.time_window_us >> 3) + 32'd1;
          case ($urandom_range(0, 19))
            0: t = model_last_turn + model_cfg.time_window_us - 32'd1;
            1: t = model_last_turn + model_cfg.time_window_us;
            2: t = now_us + $urandom;
            default: t = now_us + $urandom_range(0, step_max);
          endcase
        end
        now_us = t;
        send_move(mv, absf, t, 1'b0, 1'b0);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
